### hw/rtl/ioc_pkg.sv
package ioc_pkg;

    // Interrupt flag bit positions
    localparam logic [2:0] RD_FLAG_POS = 3'd4;
    localparam logic [2:0] TD_FLAG_POS = 3'd3;
    localparam logic [2:0] TP_FLAG_POS = 3'd0;

    // Field widths
    localparam int unsigned DIV_W = 12;
    localparam int unsigned CNT_W = 16;

    // Chip select: address bits 12 and 13 both set
    localparam logic [15:0] SEL_MASK = 16'h3000;

    // Transaction action codes
    localparam logic [1:0] ACT_READ    = 2'd0;
    localparam logic [1:0] ACT_WRITE   = 2'd1;
    localparam logic [1:0] ACT_TICK    = 2'd2;
    localparam logic [1:0] ACT_TP_EDGE = 2'd3;

    // Register numbers (address bits 3:0)
    localparam logic [3:0] REG_U   = 4'h5;
    localparam logic [3:0] REG_TX  = 4'h6;
    localparam logic [3:0] REG_F   = 4'h7;
    localparam logic [3:0] REG_C   = 4'h8;
    localparam logic [3:0] REG_G   = 4'h9;
    localparam logic [3:0] REG_MSK = 4'hA;
    localparam logic [3:0] REG_IFL = 4'hB;
    localparam logic [3:0] REG_DDA = 4'hC;
    localparam logic [3:0] REG_DDB = 4'hD;
    localparam logic [3:0] REG_A   = 4'hE;
    localparam logic [3:0] REG_B   = 4'hF;

    typedef struct packed {
        logic [1:0]  action;
        logic [15:0] address;
        logic [7:0]  write_data;
        logic [15:0] tick_cycles;
        logic [7:0]  rx_byte;
        logic        tp_pin;
        logic        rtc_data_pin;
        logic        on_key_pin;
    } t_in_item;

    typedef struct packed {
        logic [7:0] read_data;
        logic [7:0] port_a_level;
        logic [7:0] port_c_level;
        logic       buzzer_on;
        logic [7:0] tx_data;
        logic       tx_busy;
        logic [7:0] flags_now;
    } t_out_item;

endpackage

### hw/rtl/ioc_in_if.sv
interface ioc_in_if;
    logic        valid;
    logic        ready;
    logic [1:0]  action;
    logic [15:0] address;
    logic [7:0]  write_data;
    logic [15:0] tick_cycles;
    logic [7:0]  rx_byte;
    logic        tp_pin;
    logic        rtc_data_pin;
    logic        on_key_pin;

    modport source (
        output valid, action, address, write_data, tick_cycles, rx_byte,
               tp_pin, rtc_data_pin, on_key_pin,
        input  ready
    );

    modport sink (
        input  valid, action, address, write_data, tick_cycles, rx_byte,
               tp_pin, rtc_data_pin, on_key_pin,
        output ready
    );
endinterface

### hw/rtl/ioc_out_if.sv
interface ioc_out_if;
    logic       valid;
    logic       ready;
    logic [7:0] read_data;
    logic [7:0] port_a_level;
    logic [7:0] port_c_level;
    logic       buzzer_on;
    logic [7:0] tx_data;
    logic       tx_busy;
    logic [7:0] flags_now;

    modport source (
        output valid, read_data, port_a_level, port_c_level, buzzer_on,
               tx_data, tx_busy, flags_now,
        input  ready
    );

    modport sink (
        input  valid, read_data, port_a_level, port_c_level, buzzer_on,
               tx_data, tx_busy, flags_now,
        output ready
    );
endinterface

### hw/rtl/ioc_core.sv
module ioc_core import ioc_pkg::*; (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_cfg_we,
    input  logic [DIV_W-1:0] i_cfg_wdata,
    input  logic             i_proc,
    input  t_in_item         i_item,
    output t_out_item        o_result
);

    // Architectural state
    logic [DIV_W-1:0] r_div;
    logic [7:0]       r_f, r_c, r_g, r_msk, r_dda, r_ddb, r_a, r_b;
    logic [7:0]       r_flags;
    logic [7:0]       r_tx_hold;
    logic [CNT_W-1:0] r_cnt;

    logic [7:0]       n_f, n_c, n_g, n_msk, n_dda, n_ddb, n_a, n_b;
    logic [7:0]       n_flags;
    logic [7:0]       n_tx_hold;
    logic [CNT_W-1:0] n_cnt;

    logic             w_sel;
    logic [3:0]       w_reg;
    logic [CNT_W-1:0] w_load;
    logic [7:0]       w_rd;

    assign w_sel = (i_item.address & SEL_MASK) == SEL_MASK;
    assign w_reg = i_item.address[3:0];

    // Eleven bit times: 8d + 2d + d
    assign w_load = {1'b0, r_div, 3'b000} + {3'b000, r_div, 1'b0} + {4'b0000, r_div};

    // Next state and read data for the transaction in flight
    always_comb begin
        n_f       = r_f;
        n_c       = r_c;
        n_g       = r_g;
        n_msk     = r_msk;
        n_dda     = r_dda;
        n_ddb     = r_ddb;
        n_a       = r_a;
        n_b       = r_b;
        n_flags   = r_flags;
        n_tx_hold = r_tx_hold;
        n_cnt     = r_cnt;
        w_rd      = 8'hFF;
        unique case (i_item.action)
            ACT_READ: begin
                if (w_sel) begin
                    unique case (w_reg)
                        REG_U: begin
                            w_rd = i_item.rx_byte;
                            n_flags[RD_FLAG_POS] = 1'b0;
                        end
                        REG_F:   w_rd = r_f;
                        REG_C:   w_rd = r_c;
                        REG_G:   w_rd = r_g;
                        REG_MSK: w_rd = r_msk;
                        REG_IFL: w_rd = r_flags;
                        REG_DDA: w_rd = r_dda;
                        REG_DDB: w_rd = r_ddb;
                        REG_A:   w_rd = r_a;
                        // pins merge into the upper three bits
                        REG_B: begin
                            w_rd = {i_item.on_key_pin, i_item.rtc_data_pin,
                                    i_item.tp_pin, r_b[4:0]};
                        end
                        default: w_rd = 8'hFF;
                    endcase
                end
            end
            ACT_WRITE: begin
                if (w_sel) begin
                    unique case (w_reg)
                        REG_TX: begin
                            n_tx_hold            = i_item.write_data;
                            n_flags[TD_FLAG_POS] = 1'b0;
                            n_cnt                = w_load;
                        end
                        REG_IFL: n_flags = i_item.write_data;
                        REG_F:   n_f     = i_item.write_data;
                        REG_C:   n_c     = i_item.write_data;
                        REG_G:   n_g     = i_item.write_data;
                        REG_MSK: n_msk   = i_item.write_data;
                        REG_DDA: n_dda   = i_item.write_data;
                        REG_DDB: n_ddb   = i_item.write_data;
                        REG_A:   n_a     = i_item.write_data;
                        REG_B:   n_b     = i_item.write_data;
                        default: ;
                    endcase
                end
            end
            ACT_TICK: begin
                // countdown saturates at zero and then raises the transmit flag
                if (r_cnt != '0) begin
                    if (i_item.tick_cycles >= r_cnt) begin
                        n_cnt                = '0;
                        n_flags[TD_FLAG_POS] = 1'b1;
                    end else begin
                        n_cnt = r_cnt - i_item.tick_cycles;
                    end
                end
            end
            ACT_TP_EDGE: n_flags[TP_FLAG_POS] = 1'b1;
            default: ;
        endcase
    end

    // Result reflects the state after this transaction
    always_comb begin
        o_result.read_data    = w_rd;
        o_result.port_a_level = (n_a & n_dda) | ~n_dda;
        o_result.port_c_level = n_c;
        o_result.buzzer_on    = n_c[6];
        o_result.tx_data      = n_tx_hold;
        o_result.tx_busy      = n_cnt != '0;
        o_result.flags_now    = n_flags;
    end

    // State registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_div     <= DIV_W'(1);
            r_f       <= '0;
            r_c       <= '0;
            r_g       <= '0;
            r_msk     <= '0;
            r_dda     <= '0;
            r_ddb     <= '0;
            r_a       <= '0;
            r_b       <= '0;
            r_flags   <= '0;
            r_tx_hold <= '0;
            r_cnt     <= '0;
        end else begin
            if (i_cfg_we) begin
                r_div <= i_cfg_wdata;
            end
            if (i_proc) begin
                r_f       <= n_f;
                r_c       <= n_c;
                r_g       <= n_g;
                r_msk     <= n_msk;
                r_dda     <= n_dda;
                r_ddb     <= n_ddb;
                r_a       <= n_a;
                r_b       <= n_b;
                r_flags   <= n_flags;
                r_tx_hold <= n_tx_hold;
                r_cnt     <= n_cnt;
            end
        end
    end

`ifndef SYNTH
    logic w_tx_write;
    assign w_tx_write = i_proc && w_sel && (i_item.action == ACT_WRITE) && (w_reg == REG_TX);

    a_cnt_only_reloads: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !w_tx_write |=> r_cnt <= $past(r_cnt))
        else $error("transmit countdown rose without a transmit write");

    a_idle_holds: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !i_proc |=> $stable(r_flags) && $stable(r_cnt) && $stable(r_tx_hold))
        else $error("state changed with no transaction in flight");

    a_tick_expires: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_proc && i_item.action == ACT_TICK && r_cnt != '0 && i_item.tick_cycles >= r_cnt)
        |=> r_flags[TD_FLAG_POS] && r_cnt == '0)
        else $error("expired countdown did not set the transmit flag");

    a_u_read_clears: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_proc && w_sel && i_item.action == ACT_READ && w_reg == REG_U)
        |=> !r_flags[RD_FLAG_POS])
        else $error("receive register read left the receive flag set");
`endif

endmodule

### hw/rtl/io_port_controller_registers_top.sv
// I/O port controller register block on a 16-bit bus. Each input transaction is a bus read,
// a bus write, a clock tick for the transmit timer or a timer-pulse edge, and yields exactly one
// result transaction with the read byte (0xFF when nothing is read), the port A and C levels,
// the buzzer drive, the transmit byte and busy state, and the interrupt flags after the
// transaction. The block takes one transaction every cycle unless the result side stalls; the
// result is loaded from the input register into the result register once the result register
// is free or being drained and is valid from then on, and a stalled result register holds the
// input side after one more transaction. The per-cycle logic is set by the transmit countdown's
// 16-bit compare and subtract. The transmit divisor must be written via i_cfg_we/i_cfg_wdata
// only while no transaction is in flight; the block itself does not enforce this.
module io_port_controller_registers_top import ioc_pkg::*; (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_cfg_we,
    input  logic [DIV_W-1:0] i_cfg_wdata,
    ioc_in_if.sink           i_in,
    ioc_out_if.source        o_out
);

    logic      r_in_valid;
    t_in_item  r_in_item;
    logic      r_out_valid;
    t_out_item r_out_item;

    logic      w_in_accept;
    logic      w_s1_move;
    t_out_item w_result;

    // Input stage advances whenever the result register is free or being drained
    assign w_s1_move   = r_in_valid && (!r_out_valid || o_out.ready);
    assign i_in.ready  = !r_in_valid || w_s1_move;
    assign w_in_accept = i_in.valid && i_in.ready;

    // Register state and next-state logic
    ioc_core u_core (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_wdata (i_cfg_wdata),
        .i_proc      (w_s1_move),
        .i_item      (r_in_item),
        .o_result    (w_result)
    );

    // Valid flags
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid  <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            if (w_in_accept) begin
                r_in_valid <= 1'b1;
            end else if (w_s1_move) begin
                r_in_valid <= 1'b0;
            end
            if (w_s1_move) begin
                r_out_valid <= 1'b1;
            end else if (o_out.ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    // Payload registers
    always_ff @(posedge i_clk) begin
        if (w_in_accept) begin
            r_in_item.action       <= i_in.action;
            r_in_item.address      <= i_in.address;
            r_in_item.write_data   <= i_in.write_data;
            r_in_item.tick_cycles  <= i_in.tick_cycles;
            r_in_item.rx_byte      <= i_in.rx_byte;
            r_in_item.tp_pin       <= i_in.tp_pin;
            r_in_item.rtc_data_pin <= i_in.rtc_data_pin;
            r_in_item.on_key_pin   <= i_in.on_key_pin;
        end
        if (w_s1_move) begin
            r_out_item <= w_result;
        end
    end

    // Result channel
    assign o_out.valid        = r_out_valid;
    assign o_out.read_data    = r_out_item.read_data;
    assign o_out.port_a_level = r_out_item.port_a_level;
    assign o_out.port_c_level = r_out_item.port_c_level;
    assign o_out.buzzer_on    = r_out_item.buzzer_on;
    assign o_out.tx_data      = r_out_item.tx_data;
    assign o_out.tx_busy      = r_out_item.tx_busy;
    assign o_out.flags_now    = r_out_item.flags_now;

endmodule

### test/tb_io_port_controller_registers_top.sv
`timescale 1ns / 1ps

module tb_io_port_controller_registers_top;
    import ioc_pkg::*;

    logic             i_clk;
    logic             i_rst_n;
    logic             i_cfg_we;
    logic [DIV_W-1:0] i_cfg_wdata;

    ioc_in_if  in_bus();
    ioc_out_if out_bus();

    io_port_controller_registers_top dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_wdata (i_cfg_wdata),
        .i_in        (in_bus),
        .o_out       (out_bus)
    );

    // Stimulus and scoreboard storage
    t_in_item  bus_txn_q[$];
    t_out_item port_state_q[$];

    int unsigned queued_cnt;
    int unsigned accepted_cnt;
    int unsigned results_cnt;
    int unsigned fail_cnt;
    int unsigned src_idle_pct;
    int unsigned snk_idle_pct;
    int unsigned src_gap;
    int unsigned snk_gap;
    logic        in_fire;

    // Shadow copy of the controller state
    logic [7:0]       sh_f, sh_c, sh_g, sh_msk, sh_dda, sh_ddb, sh_a, sh_b;
    logic [7:0]       sh_irq;
    logic [7:0]       sh_tx_hold;
    logic [CNT_W-1:0] sh_tx_count;
    logic [DIV_W-1:0] sh_divisor;

    // Clock
    initial begin
        i_clk = 1'b0;
        forever #4 i_clk = ~i_clk;
    end

    // Compute the result of one transaction and advance the shadow state
    function automatic t_out_item port_state_after(t_in_item it);
        t_out_item  r;
        logic       sel;
        logic [3:0] rn;
        sel = (it.address & SEL_MASK) == SEL_MASK;
        rn  = it.address[3:0];
        r.read_data = 8'hFF;
        case (it.action)
            ACT_READ: if (sel) begin
                case (rn)
                    REG_U: begin
                        r.read_data = it.rx_byte;
                        sh_irq[RD_FLAG_POS] = 1'b0;
                    end
                    REG_F:   r.read_data = sh_f;
                    REG_C:   r.read_data = sh_c;
                    REG_G:   r.read_data = sh_g;
                    REG_MSK: r.read_data = sh_msk;
                    REG_IFL: r.read_data = sh_irq;
                    REG_DDA: r.read_data = sh_dda;
                    REG_DDB: r.read_data = sh_ddb;
                    REG_A:   r.read_data = sh_a;
                    REG_B:   r.read_data = {it.on_key_pin, it.rtc_data_pin, it.tp_pin,
                                            sh_b[4:0]};
                    default: r.read_data = 8'hFF;
                endcase
            end
            ACT_WRITE: if (sel) begin
                case (rn)
                    REG_TX: begin
                        sh_tx_hold = it.write_data;
                        sh_irq[TD_FLAG_POS] = 1'b0;
                        sh_tx_count = CNT_W'(32'd11 * sh_divisor);
                    end
                    REG_F:   sh_f   = it.write_data;
                    REG_C:   sh_c   = it.write_data;
                    REG_G:   sh_g   = it.write_data;
                    REG_MSK: sh_msk = it.write_data;
                    REG_IFL: sh_irq = it.write_data;
                    REG_DDA: sh_dda = it.write_data;
                    REG_DDB: sh_ddb = it.write_data;
                    REG_A:   sh_a   = it.write_data;
                    REG_B:   sh_b   = it.write_data;
                    default: ;
                endcase
            end
            ACT_TICK: if (sh_tx_count != 0) begin
                if (it.tick_cycles >= sh_tx_count) begin
                    sh_tx_count = '0;
                    sh_irq[TD_FLAG_POS] = 1'b1;
                end else begin
                    sh_tx_count = sh_tx_count - it.tick_cycles;
                end
            end
            default: sh_irq[TP_FLAG_POS] = 1'b1;
        endcase
        r.port_a_level = (sh_a & sh_dda) | ~sh_dda;
        r.port_c_level = sh_c;
        r.buzzer_on    = sh_c[6];
        r.tx_data      = sh_tx_hold;
        r.tx_busy      = sh_tx_count != 0;
        r.flags_now    = sh_irq;
        return r;
    endfunction

    task automatic check_field(input string name, input logic [7:0] exp_v,
                               input logic [7:0] got_v);
        if (got_v !== exp_v) begin
            $display("%0t: %s mismatch, expected %02h actual %02h", $time, name, exp_v, got_v);
            fail_cnt++;
        end
    endtask

    // Monitor: predict on input transactions, compare on output transactions
    always @(posedge i_clk) begin : mon
        t_out_item want;
        if (!i_rst_n) begin
            in_fire <= 1'b0;
        end else begin
            in_fire <= in_bus.valid && in_bus.ready;
            if (i_cfg_we)
                sh_divisor = i_cfg_wdata;
            if (out_bus.valid && out_bus.ready) begin
                results_cnt <= results_cnt + 1;
                if (port_state_q.size() == 0) begin
                    $display("%0t: unexpected result, expected none actual %02h",
                             $time, out_bus.read_data);
                    fail_cnt++;
                end else begin
                    want = port_state_q.pop_front();
                    check_field("read_data", want.read_data, out_bus.read_data);
                    check_field("port_a_level", want.port_a_level, out_bus.port_a_level);
                    check_field("port_c_level", want.port_c_level, out_bus.port_c_level);
                    check_field("buzzer_on", 8'(want.buzzer_on), 8'(out_bus.buzzer_on));
                    check_field("tx_data", want.tx_data, out_bus.tx_data);
                    check_field("tx_busy", 8'(want.tx_busy), 8'(out_bus.tx_busy));
                    check_field("flags_now", want.flags_now, out_bus.flags_now);
                end
            end
            if (in_bus.valid && in_bus.ready) begin
                accepted_cnt <= accepted_cnt + 1;
                port_state_q.insert(port_state_q.size(), port_state_after({in_bus.action,
                    in_bus.address, in_bus.write_data, in_bus.tick_cycles, in_bus.rx_byte,
                    in_bus.tp_pin, in_bus.rtc_data_pin, in_bus.on_key_pin}));
            end
        end
    end

    // Driver: source side, holds a transaction until it is taken
    always @(negedge i_clk) begin : drv
        t_in_item nxt;
        if (i_rst_n) begin
            if (in_bus.valid && !in_fire) begin
                // still waiting for ready
            end else if (src_gap != 0) begin
                in_bus.valid <= 1'b0;
                src_gap <= src_gap - 1;
            end else if (bus_txn_q.size() != 0) begin
                nxt = bus_txn_q.pop_front();
                in_bus.valid        <= 1'b1;
                in_bus.action       <= nxt.action;
                in_bus.address      <= nxt.address;
                in_bus.write_data   <= nxt.write_data;
                in_bus.tick_cycles  <= nxt.tick_cycles;
                in_bus.rx_byte      <= nxt.rx_byte;
                in_bus.tp_pin       <= nxt.tp_pin;
                in_bus.rtc_data_pin <= nxt.rtc_data_pin;
                in_bus.on_key_pin   <= nxt.on_key_pin;
                if ($urandom_range(0, 99) < src_idle_pct)
                    src_gap <= $urandom_range(1, 14);
            end else begin
                in_bus.valid <= 1'b0;
            end
        end
    end

    // Driver: sink side ready with random stall bursts
    always @(negedge i_clk) begin
        if (i_rst_n) begin
            if (snk_gap != 0) begin
                out_bus.ready <= 1'b0;
                snk_gap <= snk_gap - 1;
            end else begin
                out_bus.ready <= 1'b1;
                if ($urandom_range(0, 99) < snk_idle_pct)
                    snk_gap <= $urandom_range(1, 14);
            end
        end
    end

    task automatic push_txn(input logic [1:0] act, input logic [15:0] addr,
                            input logic [7:0] wd, input logic [15:0] cyc);
        t_in_item it;
        it.action       = act;
        it.address      = addr;
        it.write_data   = wd;
        it.tick_cycles  = cyc;
        it.rx_byte      = 8'($urandom);
        it.tp_pin       = 1'($urandom);
        it.rtc_data_pin = 1'($urandom);
        it.on_key_pin   = 1'($urandom);
        bus_txn_q.insert(bus_txn_q.size(), it);
        queued_cnt++;
    endtask

    // Random transaction: mostly selected accesses, some unselected noise
    task automatic push_random(input int unsigned span);
        int unsigned p;
        logic [1:0]  act;
        logic [15:0] addr;
        logic [15:0] cyc;
        addr = 16'($urandom);
        if ($urandom_range(0, 9) < 8)
            addr[13:12] = 2'b11;
        p = $urandom_range(0, 99);
        if (p < 28)
            act = ACT_READ;
        else if (p < 58)
            act = ACT_WRITE;
        else if (p < 88)
            act = ACT_TICK;
        else
            act = ACT_TP_EDGE;
        // bias writes toward starting a transmit
        if (act == ACT_WRITE && $urandom_range(0, 3) == 0)
            addr[3:0] = REG_TX;
        p = $urandom_range(0, 2);
        if (p == 0)
            cyc = 16'($urandom);
        else if (p == 1)
            cyc = 16'($urandom_range(0, span));
        else
            cyc = 16'($urandom_range(0, 15));
        push_txn(act, addr, 8'($urandom), cyc);
    endtask

    task automatic wait_idle();
        do
            @(posedge i_clk);
        while (accepted_cnt != queued_cnt || results_cnt != queued_cnt);
        repeat (4) @(posedge i_clk);
    endtask

    task automatic set_divisor(input logic [DIV_W-1:0] v);
        wait_idle();
        @(negedge i_clk);
        i_cfg_we    <= 1'b1;
        i_cfg_wdata <= v;
        @(negedge i_clk);
        i_cfg_we    <= 1'b0;
    endtask

    task automatic run_random(input int unsigned n, input logic [DIV_W-1:0] div);
        int unsigned span;
        span = (div == 0) ? 16 : 11 * div;
        @(posedge i_clk);
        repeat (n) push_random(span);
    endtask

    // Main sequence
    initial begin
        i_rst_n          = 1'b0;
        i_cfg_we         = 1'b0;
        i_cfg_wdata      = '0;
        in_bus.valid     = 1'b0;
        in_bus.action    = ACT_READ;
        in_bus.address   = '0;
        in_bus.write_data   = '0;
        in_bus.tick_cycles  = '0;
        in_bus.rx_byte      = '0;
        in_bus.tp_pin       = 1'b0;
        in_bus.rtc_data_pin = 1'b0;
        in_bus.on_key_pin   = 1'b0;
        out_bus.ready    = 1'b0;
        queued_cnt   = 0;
        accepted_cnt = 0;
        results_cnt  = 0;
        fail_cnt     = 0;
        src_gap      = 0;
        snk_gap      = 0;
        src_idle_pct = 15;
        snk_idle_pct = 15;
        {sh_f, sh_c, sh_g, sh_msk, sh_dda, sh_ddb, sh_a, sh_b} = '0;
        sh_irq      = '0;
        sh_tx_hold  = '0;
        sh_tx_count = '0;
        sh_divisor  = 1;

        repeat (5) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // Directed: decode edges, every register, flag behavior, transmit countdown
        push_txn(ACT_READ,  16'h0000, 8'h00, 16'h0000);
        push_txn(ACT_WRITE, 16'h2FFF, 8'hAA, 16'hFFFF);
        push_txn(ACT_READ,  16'hFFFF, 8'hFF, 16'h0000);
        push_txn(ACT_WRITE, {12'h300, REG_DDA}, 8'hF0, 16'h0000);
        push_txn(ACT_WRITE, {12'h300, REG_A},   8'h5A, 16'h0000);
        push_txn(ACT_WRITE, {12'hF30, REG_C},   8'hFF, 16'h0000);
        push_txn(ACT_WRITE, {12'h300, REG_F},   8'h00, 16'h0000);
        push_txn(ACT_WRITE, {12'h300, REG_G},   8'hFF, 16'h0000);
        push_txn(ACT_WRITE, {12'h300, REG_MSK}, 8'h80, 16'h0000);
        push_txn(ACT_WRITE, {12'h300, REG_DDB}, 8'h01, 16'h0000);
        push_txn(ACT_WRITE, {12'h300, REG_B},   8'hFF, 16'h0000);
        push_txn(ACT_READ,  16'h3000, 8'h00, 16'h0000);
        push_txn(ACT_READ,  16'h3004, 8'h00, 16'h0000);
        push_txn(ACT_READ,  {12'h300, REG_TX},  8'h00, 16'h0000);
        push_txn(ACT_WRITE, 16'h3001, 8'h55, 16'h0000);
        push_txn(ACT_WRITE, {12'h300, REG_U},   8'h55, 16'h0000);
        push_txn(ACT_WRITE, {12'h300, REG_IFL}, 8'hFF, 16'h0000);
        push_txn(ACT_READ,  {12'h300, REG_U},   8'h00, 16'h0000);
        push_txn(ACT_WRITE, {12'h300, REG_TX},  8'h81, 16'h0000);
        push_txn(ACT_TICK,  16'h0000, 8'h00, 16'h0000);
        push_txn(ACT_TICK,  16'h0000, 8'h00, 16'h0005);
        push_txn(ACT_TICK,  16'h0000, 8'h00, 16'hFFFF);
        push_txn(ACT_TICK,  16'h0000, 8'h00, 16'h0003);
        push_txn(ACT_TP_EDGE, 16'h0000, 8'h00, 16'h0000);
        for (int r = REG_F; r <= REG_B; r++)
            push_txn(ACT_READ, {12'h300, 4'(r)}, 8'h00, 16'h0000);

        // Random phases over several divisor settings
        set_divisor(12'd4095);
        src_idle_pct = 20;
        snk_idle_pct = 20;
        run_random(90, 12'd4095);

        set_divisor(12'd0);
        run_random(70, 12'd0);

        set_divisor(12'd2);
        src_idle_pct = 0;
        snk_idle_pct = 30;
        run_random(90, 12'd2);

        set_divisor(12'd1);
        src_idle_pct = 30;
        snk_idle_pct = 0;
        run_random(90, 12'd1);

        // Closing stretch at full rate
        set_divisor(12'($urandom_range(1, 4095)));
        src_idle_pct = 0;
        snk_idle_pct = 0;
        run_random(90, sh_divisor);

        wait_idle();
        repeat (8) @(posedge i_clk);
        @(negedge i_clk);
        if (port_state_q.size() != 0) begin
            $display("%0t: %0d results missing, expected 0 actual %0d", $time,
                     port_state_q.size(), port_state_q.size());
            fail_cnt++;
        end
        if (fail_cnt == 0)
            $display("CHECK OK");
        else
            $display("CHECK FAILED");
        $finish;
    end

    // Run limit
    initial begin
        #3ms;
        $display("CHECK FAILED");
        $finish;
    end

endmodule
